[hdl/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked implication checks on aclk, masked while aresetn is low.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_IMPLY(label, ante, cons, msg)
`define ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

[hdl/rbf_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rbf_pkg
// Shared constants, types and controller/datapath interface structs.
// ---------------------------------------------------------------------------
package rbf_pkg;

    localparam int NUM_QUEUES  = 4;
    localparam int QUEUE_DEPTH = 16;
    localparam int MAX_RESULTS = 64;

    localparam int QID_W      = 2;
    localparam int PTR_W      = $clog2(QUEUE_DEPTH);
    localparam int ADDR_W     = QID_W + PTR_W;
    localparam int CNT_W      = PTR_W + 1;
    localparam int TAG_W      = 16;
    localparam int TIME_W     = 16;
    localparam int BN_W       = 32;
    localparam int MBS_W      = 5;
    localparam int IDX_W      = 4;
    localparam int NRES_W     = $clog2(MAX_RESULTS + 1);
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_BATCH = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT   = CFG_IDX_W'(1);

    localparam logic REQ_SUBMIT = 1'b0;
    localparam logic REQ_TICK   = 1'b1;

    localparam logic [MBS_W-1:0]  MAX_BATCH_CAP = MBS_W'(16);
    localparam logic [MBS_W-1:0]  MAX_BATCH_RST = MBS_W'(16);
    localparam logic [TIME_W-1:0] TIMEOUT_RST   = TIME_W'(10);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_APPEND,
        ST_CHECK_RD,
        ST_EVAL,
        ST_ISSUE,
        ST_FLUSH
    } ctl_state_t;

    typedef struct packed {
        logic take;
        logic append;
        logic tick_inc;
        logic q_first;
        logic q_next;
        logic rd_head;
        logic start_batch;
        logic issue;
        logic end_batch;
        logic flush;
    } ctl_cmd_t;

    typedef struct packed {
        logic is_tick;
        logic q_valid;
        logic q_last;
        logic cnt_zero;
        logic fire;
        logic fits;
        logic k_done;
        logic adv;
        logic pipe_valid;
        logic hold_valid;
    } ctl_sts_t;

    typedef struct packed {
        logic [QID_W-1:0]  queue;
        logic [TAG_W-1:0]  tag;
        logic [BN_W-1:0]   number;
        logic [MBS_W-1:0]  size;
        logic [IDX_W-1:0]  index;
        logic [TIME_W-1:0] wait_ticks;
        logic              leader;
        logic              tflush;
    } rbf_res_t;

endpackage

[hdl/rbf_ctrl.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rbf_ctrl
// Sequencer: accept, append or tick, per-queue check and release walk, flush.
// ---------------------------------------------------------------------------
module rbf_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  rbf_pkg::ctl_sts_t sts,
    output rbf_pkg::ctl_cmd_t cmd
);
    import rbf_pkg::*;

    ctl_state_t state_reg;
    ctl_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = (state_reg == ST_IDLE);
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.take   = 1'b1;
                    state_next = ST_START;
                end
            end
            ST_START: begin
                cmd.q_first = 1'b1;
                if (sts.is_tick) begin
                    cmd.tick_inc = 1'b1;
                    state_next   = ST_CHECK_RD;
                end else if (sts.q_valid) begin
                    state_next = ST_APPEND;
                end else begin
                    state_next = ST_FLUSH;
                end
            end
            ST_APPEND: begin
                cmd.append = 1'b1;
                state_next = ST_CHECK_RD;
            end
            ST_CHECK_RD: begin
                if (sts.adv) begin
                    cmd.rd_head = 1'b1;
                    state_next  = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (!sts.cnt_zero && sts.fire && sts.fits) begin
                    cmd.start_batch = 1'b1;
                    state_next      = ST_ISSUE;
                end else if (!sts.is_tick || sts.q_last) begin
                    state_next = ST_FLUSH;
                end else begin
                    cmd.q_next = 1'b1;
                    state_next = ST_CHECK_RD;
                end
            end
            ST_ISSUE: begin
                if (sts.adv) begin
                    cmd.issue = 1'b1;
                    if (sts.k_done) begin
                        cmd.end_batch = 1'b1;
                        state_next    = ST_CHECK_RD;
                    end
                end
            end
            ST_FLUSH: begin
                if (sts.adv) begin
                    cmd.flush  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[hdl/rbf_dpath.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rbf_dpath
// Queue store, per-queue pointers, release tests, read pipe and output words.
// ---------------------------------------------------------------------------
module rbf_dpath (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    input  logic [rbf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rbf_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              s_req_type,
    input  logic [rbf_pkg::QID_W-1:0]         s_queue_id,
    input  logic [rbf_pkg::TAG_W-1:0]         s_request_tag,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [rbf_pkg::QID_W-1:0]         m_out_queue,
    output logic [rbf_pkg::TAG_W-1:0]         m_out_tag,
    output logic [rbf_pkg::BN_W-1:0]          m_batch_seq,
    output logic [rbf_pkg::MBS_W-1:0]         m_batch_len,
    output logic [rbf_pkg::IDX_W-1:0]         m_batch_pos,
    output logic [rbf_pkg::TIME_W-1:0]        m_wait_ticks,
    output logic                              m_leader,
    output logic                              m_timeout_flush,
    output logic                              m_last,
    input  rbf_pkg::ctl_cmd_t                 cmd,
    output rbf_pkg::ctl_sts_t                 sts
);
    import rbf_pkg::*;

    localparam int MEM_DEPTH = NUM_QUEUES * QUEUE_DEPTH;

    // configuration
    logic [MBS_W-1:0]  max_reg;
    logic [TIME_W-1:0] to_reg;

    // current item
    logic              item_type_reg;
    logic [QID_W-1:0]  item_q_reg;
    logic [TAG_W-1:0]  item_tag_reg;

    // queue state
    logic [CNT_W-1:0]  count_reg [NUM_QUEUES];
    logic [PTR_W-1:0]  head_reg  [NUM_QUEUES];
    logic [TIME_W-1:0] tick_reg;
    logic [BN_W-1:0]   bcnt_reg;

    // walk state
    logic [QID_W-1:0]  qi_reg;
    logic [IDX_W-1:0]  k_reg;
    logic [NRES_W-1:0] n_reg;
    logic [MBS_W-1:0]  rc_reg;
    logic              tflag_reg;
    logic [BN_W-1:0]   bnum_reg;

    // store: {tag, arrival}
    logic [TAG_W+TIME_W-1:0] mem [MEM_DEPTH];
    logic [TAG_W+TIME_W-1:0] rd_data_reg;

    logic              pipe_valid_reg;
    logic [IDX_W-1:0]  pipe_k_reg;

    rbf_res_t          hold_reg;
    logic              hold_valid_reg;
    rbf_res_t          out_reg;
    logic              out_last_reg;
    logic              out_valid_reg;

    logic [CNT_W-1:0]  cnt;
    logic [PTR_W-1:0]  head;
    logic [MBS_W-1:0]  m_eff;
    logic [TIME_W-1:0] to_eff;
    logic [TIME_W-1:0] w0;
    logic              size_hit;
    logic              time_hit;
    logic [MBS_W-1:0]  rc;
    logic [NRES_W:0]   n_sum;
    logic              full;
    logic              adv;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;
    logic              wr_en;
    rbf_res_t          res_new;

    always_comb begin
        cnt    = count_reg[qi_reg];
        head   = head_reg[qi_reg];
        if (max_reg == '0) begin
            m_eff = MBS_W'(1);
        end else if (max_reg > MAX_BATCH_CAP) begin
            m_eff = MAX_BATCH_CAP;
        end else begin
            m_eff = max_reg;
        end
        to_eff   = (to_reg == '0) ? TIME_W'(1) : to_reg;
        w0       = tick_reg - rd_data_reg[TIME_W-1:0];
        size_hit = MBS_W'(cnt) >= m_eff;
        time_hit = w0 >= to_eff;
        rc       = size_hit ? m_eff : MBS_W'(cnt);
        n_sum    = {1'b0, n_reg} + (NRES_W+1)'(rc);
        full     = (cnt == CNT_W'(QUEUE_DEPTH));
        adv      = !out_valid_reg || m_ready;
        rd_en    = cmd.rd_head || cmd.issue;
        rd_addr  = cmd.issue ? {qi_reg, head + PTR_W'(k_reg)} : {qi_reg, head};
        wr_en    = cmd.append && !full;
        wr_addr  = {qi_reg, head + cnt[PTR_W-1:0]};

        res_new.queue      = qi_reg;
        res_new.tag        = rd_data_reg[TAG_W+TIME_W-1:TIME_W];
        res_new.number     = bnum_reg;
        res_new.size       = rc_reg;
        res_new.index      = pipe_k_reg;
        res_new.wait_ticks = tick_reg - rd_data_reg[TIME_W-1:0];
        res_new.leader     = (pipe_k_reg == '0);
        res_new.tflush     = tflag_reg;

        sts.is_tick    = (item_type_reg == REQ_TICK);
        sts.q_valid    = ({1'b0, item_q_reg} < (QID_W+1)'(NUM_QUEUES));
        sts.q_last     = (qi_reg == QID_W'(NUM_QUEUES - 1));
        sts.cnt_zero   = (cnt == '0);
        sts.fire       = size_hit || time_hit;
        sts.fits       = n_sum <= (NRES_W+1)'(MAX_RESULTS);
        sts.k_done     = ({1'b0, k_reg} + MBS_W'(1)) == rc_reg;
        sts.adv        = adv;
        sts.pipe_valid = pipe_valid_reg;
        sts.hold_valid = hold_valid_reg;
    end

    // store
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= {item_tag_reg, tick_reg};
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_reg        <= MAX_BATCH_RST;
            to_reg         <= TIMEOUT_RST;
            tick_reg       <= '0;
            bcnt_reg       <= '0;
            pipe_valid_reg <= 1'b0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < NUM_QUEUES; i++) begin
                count_reg[i] <= '0;
                head_reg[i]  <= '0;
            end
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    REG_MAX_BATCH: max_reg <= cfg_data[MBS_W-1:0];
                    REG_TIMEOUT:   to_reg  <= cfg_data[TIME_W-1:0];
                    default:       ;
                endcase
            end
            if (cmd.tick_inc) begin
                tick_reg <= tick_reg + TIME_W'(1);
            end
            if (wr_en) begin
                count_reg[qi_reg] <= cnt + CNT_W'(1);
            end
            if (cmd.end_batch) begin
                head_reg[qi_reg]  <= head + rc_reg[PTR_W-1:0];
                count_reg[qi_reg] <= cnt - CNT_W'(rc_reg);
                bcnt_reg          <= bcnt_reg + BN_W'(1);
            end
            if (adv) begin
                pipe_valid_reg <= cmd.issue;
                out_valid_reg  <= hold_valid_reg && (pipe_valid_reg || cmd.flush);
                if (pipe_valid_reg) begin
                    hold_valid_reg <= 1'b1;
                end else if (cmd.flush) begin
                    hold_valid_reg <= 1'b0;
                end
            end
        end
    end

    // walk payload
    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            item_type_reg <= s_req_type;
            item_q_reg    <= s_queue_id;
            item_tag_reg  <= s_request_tag;
            n_reg         <= '0;
        end
        if (cmd.q_first) begin
            qi_reg <= (item_type_reg == REQ_TICK) ? '0 : item_q_reg;
        end else if (cmd.q_next) begin
            qi_reg <= qi_reg + QID_W'(1);
        end
        if (cmd.start_batch) begin
            rc_reg    <= rc;
            tflag_reg <= time_hit && !size_hit;
            bnum_reg  <= bcnt_reg;
            k_reg     <= '0;
            n_reg     <= n_sum[NRES_W-1:0];
        end else if (cmd.issue) begin
            k_reg <= k_reg + IDX_W'(1);
        end
        if (adv) begin
            pipe_k_reg <= k_reg;
            if (pipe_valid_reg) begin
                hold_reg <= res_new;
            end
            if (hold_valid_reg && (pipe_valid_reg || cmd.flush)) begin
                out_reg      <= hold_reg;
                out_last_reg <= cmd.flush;
            end
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_out_queue     = out_reg.queue;
    assign m_out_tag       = out_reg.tag;
    assign m_batch_seq     = out_reg.number;
    assign m_batch_len     = out_reg.size;
    assign m_batch_pos     = out_reg.index;
    assign m_wait_ticks    = out_reg.wait_ticks;
    assign m_leader        = out_reg.leader;
    assign m_timeout_flush = out_reg.tflush;
    assign m_last          = out_last_reg;

endmodule

[hdl/request_batch_former_unit.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// request_batch_former_unit
// Per-queue request batching, released on batch size or on timeout.
// ---------------------------------------------------------------------------
//  channel  dir  handshake            word
//  s_       in   s_valid / s_ready    req_type, queue_id, request_tag
//  m_       out  m_valid / m_ready    one released request, last marks item end
//  cfg_     in   cfg_valid/cfg_ready  cfg_index (0 max batch, 1 timeout), cfg_data
//
// Released batches go out one word per cycle while m_ is not stalled, read
// from the tag/arrival store, which has separate read and write ports.
// The final word of an item is held one stage until the item's checks finish.
// Reset is synchronous; queues empty, time and batch number zero, no clear pass.
// A stalled m_ channel freezes the release walk; config is always ready.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module request_batch_former_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [rbf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rbf_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_req_type,
    input  logic [rbf_pkg::QID_W-1:0]         s_queue_id,
    input  logic [rbf_pkg::TAG_W-1:0]         s_request_tag,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [rbf_pkg::QID_W-1:0]         m_out_queue,
    output logic [rbf_pkg::TAG_W-1:0]         m_out_tag,
    output logic [rbf_pkg::BN_W-1:0]          m_batch_seq,
    output logic [rbf_pkg::MBS_W-1:0]         m_batch_len,
    output logic [rbf_pkg::IDX_W-1:0]         m_batch_pos,
    output logic [rbf_pkg::TIME_W-1:0]        m_wait_ticks,
    output logic                              m_leader,
    output logic                              m_timeout_flush,
    output logic                              m_last
);
    import rbf_pkg::*;

    ctl_cmd_t cmd;
    ctl_sts_t sts;

    assign cfg_ready = 1'b1;

    rbf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    rbf_dpath u_dpath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_req_type      (s_req_type),
        .s_queue_id      (s_queue_id),
        .s_request_tag   (s_request_tag),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_queue     (m_out_queue),
        .m_out_tag       (m_out_tag),
        .m_batch_seq     (m_batch_seq),
        .m_batch_len     (m_batch_len),
        .m_batch_pos     (m_batch_pos),
        .m_wait_ticks    (m_wait_ticks),
        .m_leader        (m_leader),
        .m_timeout_flush (m_timeout_flush),
        .m_last          (m_last),
        .cmd             (cmd),
        .sts             (sts)
    );

    `ASSERT_IMPLY(a_idle_hold_empty, s_ready, !sts.hold_valid, "word left in hold at idle")
    `ASSERT_IMPLY(a_issue_nonempty, cmd.issue, !sts.cnt_zero, "release walk on empty queue")
    `ASSERT_IMPLY(a_flush_drained, cmd.flush, !sts.pipe_valid, "flush with read in flight")
    `ASSERT_NEXT(a_flush_to_idle, cmd.flush, s_ready, "no return to idle after flush")

endmodule

[dv/tb_request_batch_former_unit.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_request_batch_former_unit
// Self-checking bench for the request batch former. A directed table covers
// the register extremes, both request kinds and the size and timeout release
// paths, with hand-written words where they are obvious. Random traffic then
// fills every queue to the brink and flushes it at once, and runs phases of
// random settings. Every word is checked against a batching predictor, under
// bursty input and a stalling output.
// ---------------------------------------------------------------------------
module tb_request_batch_former_unit;
    import rbf_pkg::*;

    typedef struct packed {
        logic [QID_W-1:0]  queue;
        logic [TAG_W-1:0]  tag;
        logic [BN_W-1:0]   number;
        logic [MBS_W-1:0]  size;
        logic [IDX_W-1:0]  index;
        logic [TIME_W-1:0] waited;
        logic              leader;
        logic              tflush;
        logic              last;
    } batch_word_t;

    typedef enum logic [1:0] {ROW_SUBMIT, ROW_TICK, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  addr;
        logic [CFG_DATA_W-1:0] data;
        bit                    typed;
        batch_word_t           word;
    } row_t;

    localparam logic [7:0] RX_PATTERN = 8'b1101_0110;
    localparam int         SETTLE_CYCLES = 40;
    localparam int         LONG_HOLD = 400;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic                  s_req_type = REQ_SUBMIT;
    logic [QID_W-1:0]      s_queue_id = '0;
    logic [TAG_W-1:0]      s_request_tag = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [QID_W-1:0]      m_out_queue;
    logic [TAG_W-1:0]      m_out_tag;
    logic [BN_W-1:0]       m_batch_seq;
    logic [MBS_W-1:0]      m_batch_len;
    logic [IDX_W-1:0]      m_batch_pos;
    logic [TIME_W-1:0]     m_wait_ticks;
    logic                  m_leader;
    logic                  m_timeout_flush;
    logic                  m_last;

    request_batch_former_unit dut (.*);

    always #10 aclk = ~aclk;

    // predictor state
    logic [TAG_W-1:0]  tag_store [NUM_QUEUES][QUEUE_DEPTH];
    logic [TIME_W-1:0] arrive_at [NUM_QUEUES][QUEUE_DEPTH];
    int                fill_cnt  [NUM_QUEUES];
    logic [PTR_W-1:0]  head_idx  [NUM_QUEUES];
    logic [TIME_W-1:0] now_tick;
    logic [BN_W-1:0]   batch_seq;
    logic [MBS_W-1:0]  cfg_max;
    logic [TIME_W-1:0] cfg_wait;

    batch_word_t step_words[$];
    batch_word_t due_words[$];
    int          mismatches = 0;

    bit   idle_on = 1'b1;
    int   gap_max = 6;
    int   burst_left = 0;
    bit   hold_req = 1'b0;
    bit   hold_done = 1'b0;
    int   hold_cnt = 0;
    int   rx_mode = 0;
    int   rx_mode_left = 0;
    logic [2:0] rx_cycle = '0;

    function automatic void release_ready_batches(input int q);
        int                m, to, cnt, rc;
        logic [TIME_W-1:0] w0;
        logic              size_hit, time_hit;
        logic [PTR_W-1:0]  sl;
        batch_word_t       w;
        m  = (cfg_max == 0) ? 1 :
             (cfg_max > MAX_BATCH_CAP) ? int'(MAX_BATCH_CAP) : int'(cfg_max);
        to = (cfg_wait == 0) ? 1 : int'(cfg_wait);
        forever begin
            cnt = fill_cnt[q];
            if (cnt == 0) return;
            size_hit = (cnt >= m);
            w0 = now_tick - arrive_at[q][head_idx[q]];
            time_hit = (int'(w0) >= to);
            if (!size_hit && !time_hit) return;
            rc = (cnt < m) ? cnt : m;
            if (step_words.size() + rc > MAX_RESULTS) return;
            for (int k = 0; k < rc; k++) begin
                sl       = head_idx[q] + PTR_W'(k);
                w.queue  = QID_W'(q);
                w.tag    = tag_store[q][sl];
                w.number = batch_seq;
                w.size   = MBS_W'(rc);
                w.index  = IDX_W'(k);
                w.waited = now_tick - arrive_at[q][sl];
                w.leader = (k == 0);
                w.tflush = time_hit && !size_hit;
                w.last   = 1'b0;
                step_words.insert(step_words.size(), w);
            end
            head_idx[q] = head_idx[q] + PTR_W'(rc);
            fill_cnt[q] = cnt - rc;
            batch_seq   = batch_seq + 1'b1;
        end
    endfunction

    function automatic void apply_request(input logic kind, input logic [QID_W-1:0] q,
                                          input logic [TAG_W-1:0] tag);
        logic [PTR_W-1:0] sl;
        step_words.delete();
        if (kind == REQ_SUBMIT) begin
            // full queue drops the tag but is still checked
            if (fill_cnt[q] < QUEUE_DEPTH) begin
                sl = head_idx[q] + PTR_W'(fill_cnt[q]);
                tag_store[q][sl] = tag;
                arrive_at[q][sl] = now_tick;
                fill_cnt[q] = fill_cnt[q] + 1;
            end
            release_ready_batches(int'(q));
        end else begin
            now_tick = now_tick + 1'b1;
            for (int i = 0; i < NUM_QUEUES; i++) release_ready_batches(i);
        end
        if (step_words.size() != 0) step_words[step_words.size() - 1].last = 1'b1;
    endfunction

    task automatic send_request(input logic kind, input logic [QID_W-1:0] q,
                                input logic [TAG_W-1:0] tag, input bit typed,
                                input batch_word_t typed_word);
        s_valid       <= 1'b1;
        s_req_type    <= kind;
        s_queue_id    <= q;
        s_request_tag <= tag;
        do @(posedge aclk); while (!s_ready);
        apply_request(kind, q, tag);
        if (typed) due_words.insert(due_words.size(), typed_word);
        else foreach (step_words[i]) due_words.insert(due_words.size(), step_words[i]);
    endtask

    task automatic pace();
        if (!idle_on) return;
        if (burst_left > 0) begin
            burst_left--;
            return;
        end
        s_valid <= 1'b0;
        repeat ($urandom_range(1, gap_max)) @(posedge aclk);
        burst_left = $urandom_range(0, 12);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (due_words.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_MAX_BATCH) cfg_max = val[MBS_W-1:0];
        else if (idx == REG_TIMEOUT) cfg_wait = val;
    endtask

    task automatic report_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s expected %0h got %0h", $time, name, want, got);
        end
    endtask

    // result checker
    always @(posedge aclk) begin
        batch_word_t got, want;
        if (aresetn && m_valid && m_ready) begin
            got = {m_out_queue, m_out_tag, m_batch_seq, m_batch_len, m_batch_pos,
                   m_wait_ticks, m_leader, m_timeout_flush, m_last};
            if (due_words.size() == 0) begin
                mismatches++;
                $display("%0t: word with none expected, expected none got %p", $time, got);
            end else begin
                want = due_words[0];
                due_words.delete(0);
                report_field("out_queue", 32'(want.queue), 32'(got.queue));
                report_field("out_tag", 32'(want.tag), 32'(got.tag));
                report_field("batch_seq", want.number, got.number);
                report_field("batch_len", 32'(want.size), 32'(got.size));
                report_field("batch_pos", 32'(want.index), 32'(got.index));
                report_field("wait_ticks", 32'(want.waited), 32'(got.waited));
                report_field("leader", 32'(want.leader), 32'(got.leader));
                report_field("timeout_flush", 32'(want.tflush), 32'(got.tflush));
                report_field("last", 32'(want.last), 32'(got.last));
            end
        end
    end

    // receiver: random stall modes, plus one long hold on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_cnt != 0) begin
            m_ready  <= 1'b0;
            hold_cnt <= hold_cnt - 1;
        end else if (hold_req && !hold_done) begin
            m_ready   <= 1'b0;
            hold_done <= 1'b1;
            hold_cnt  <= LONG_HOLD;
        end else begin
            rx_cycle <= rx_cycle + 1'b1;
            if (rx_mode_left == 0) begin
                rx_mode      <= $urandom_range(0, 3);
                rx_mode_left <= $urandom_range(16, 96);
            end else begin
                rx_mode_left <= rx_mode_left - 1;
            end
            case (rx_mode)
                0: m_ready <= 1'b1;
                1: m_ready <= 1'($urandom_range(0, 1));
                2: m_ready <= ($urandom_range(0, 3) == 0);
                default: m_ready <= RX_PATTERN[rx_cycle];
            endcase
        end
    end

    initial begin
        #10_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        row_t             plan[$];
        logic [MBS_W-1:0] mv;
        logic [TIME_W-1:0] tv;
        logic [QID_W-1:0] q, hot;

        foreach (fill_cnt[i]) begin
            fill_cnt[i] = 0;
            head_idx[i] = '0;
        end
        now_tick  = '0;
        batch_seq = '0;
        cfg_max   = MAX_BATCH_RST;
        cfg_wait  = TIMEOUT_RST;

        plan = '{
            // zero size and zero timeout both act as one
            '{ROW_CFG, REG_MAX_BATCH, 16'h0000, 1'b0, '0},
            '{ROW_CFG, REG_TIMEOUT, 16'h0000, 1'b0, '0},
            '{ROW_SUBMIT, 4'd3, 16'hFFFF, 1'b1,
              '{2'd3, 16'hFFFF, 32'd0, 5'd1, 4'd0, 16'd0, 1'b1, 1'b0, 1'b1}},
            '{ROW_SUBMIT, 4'd0, 16'h0000, 1'b1,
              '{2'd0, 16'h0000, 32'd1, 5'd1, 4'd0, 16'd0, 1'b1, 1'b0, 1'b1}},
            '{ROW_TICK, 4'd0, 16'h0000, 1'b0, '0},
            '{ROW_CFG, REG_MAX_BATCH, 16'h0003, 1'b0, '0},
            '{ROW_CFG, REG_TIMEOUT, 16'h0002, 1'b0, '0},
            '{ROW_SUBMIT, 4'd1, 16'h1234, 1'b0, '0},
            '{ROW_SUBMIT, 4'd1, 16'h5678, 1'b0, '0},
            '{ROW_TICK, 4'd0, 16'h0000, 1'b0, '0},
            '{ROW_SUBMIT, 4'd1, 16'h9ABC, 1'b0, '0},
            '{ROW_SUBMIT, 4'd2, 16'h0001, 1'b0, '0},
            '{ROW_TICK, 4'd0, 16'h0000, 1'b0, '0},
            '{ROW_TICK, 4'd0, 16'h0000, 1'b1,
              '{2'd2, 16'h0001, 32'd3, 5'd1, 4'd0, 16'd2, 1'b1, 1'b1, 1'b1}},
            // oversize setting clamps to sixteen
            '{ROW_CFG, REG_MAX_BATCH, 16'hFFFF, 1'b0, '0},
            '{ROW_CFG, REG_TIMEOUT, 16'h0001, 1'b0, '0},
            '{ROW_SUBMIT, 4'd0, 16'hAAAA, 1'b0, '0},
            '{ROW_SUBMIT, 4'd1, 16'h5555, 1'b0, '0},
            '{ROW_SUBMIT, 4'd2, 16'h0F0F, 1'b0, '0},
            '{ROW_SUBMIT, 4'd3, 16'hF0F0, 1'b0, '0},
            '{ROW_TICK, 4'd0, 16'h0000, 1'b0, '0},
            '{ROW_CFG, REG_MAX_BATCH, 16'h0002, 1'b0, '0},
            '{ROW_CFG, REG_TIMEOUT, 16'hFFFF, 1'b0, '0},
            '{ROW_SUBMIT, 4'd0, 16'hFFFF, 1'b0, '0},
            '{ROW_SUBMIT, 4'd0, 16'h0000, 1'b0, '0},
            '{ROW_SUBMIT, 4'd2, 16'h1357, 1'b0, '0},
            '{ROW_TICK, 4'd0, 16'h0000, 1'b0, '0}
        };

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (plan[i]) begin
            case (plan[i].kind)
                ROW_CFG: begin
                    drain();
                    write_reg(plan[i].addr, plan[i].data);
                end
                ROW_TICK: begin
                    send_request(REQ_TICK, QID_W'($urandom), TAG_W'($urandom),
                                 plan[i].typed, plan[i].word);
                    pace();
                end
                default: begin
                    send_request(REQ_SUBMIT, plan[i].addr[QID_W-1:0], plan[i].data,
                                 plan[i].typed, plan[i].word);
                    pace();
                end
            endcase
        end

        // bring every queue to one below full, then flush all at once
        for (int v = 0; v < 2; v++) begin
            drain();
            write_reg(REG_MAX_BATCH, CFG_DATA_W'(MAX_BATCH_CAP));
            write_reg(REG_TIMEOUT, 16'hFFFF);
            idle_on = (v == 0);
            while (fill_cnt[0] + fill_cnt[1] + fill_cnt[2] + fill_cnt[3]
                   < NUM_QUEUES * (QUEUE_DEPTH - 1)) begin
                q = QID_W'($urandom);
                if (fill_cnt[q] < QUEUE_DEPTH - 1) begin
                    send_request(REQ_SUBMIT, q, TAG_W'($urandom), 1'b0, '0);
                    pace();
                end
            end
            drain();
            idle_on = 1'b1;
            if (v == 0) begin
                write_reg(REG_MAX_BATCH, {11'($urandom), 5'd1});
                hold_req <= 1'b1;
            end else begin
                write_reg(REG_TIMEOUT, 16'd1);
            end
            send_request(REQ_TICK, QID_W'($urandom), TAG_W'($urandom), 1'b0, '0);
            // keep offering while the output is held off
            if (v == 0) begin
                repeat (24) begin
                    send_request(REQ_SUBMIT, QID_W'($urandom), TAG_W'($urandom), 1'b0, '0);
                end
            end
        end

        for (int ph = 0; ph < 5; ph++) begin
            drain();
            case ($urandom_range(0, 5))
                0: mv = 5'd0;
                1: mv = 5'd1;
                2: mv = MAX_BATCH_CAP;
                3: mv = MBS_W'($urandom_range(17, 31));
                default: mv = MBS_W'($urandom_range(2, 8));
            endcase
            case ($urandom_range(0, 4))
                0: tv = 16'd0;
                1: tv = 16'd1;
                2: tv = 16'hFFFF;
                default: tv = TIME_W'($urandom_range(2, 12));
            endcase
            if ($urandom_range(0, 1)) begin
                write_reg(REG_MAX_BATCH, {11'($urandom), mv});
                write_reg(REG_TIMEOUT, tv);
            end else begin
                write_reg(REG_TIMEOUT, tv);
                write_reg(REG_MAX_BATCH, {11'($urandom), mv});
            end
            idle_on = ($urandom_range(0, 3) != 0);
            gap_max = $urandom_range(2, 20);
            hot = QID_W'($urandom);
            repeat (8) begin
                if ($urandom_range(0, 9) < 3) begin
                    send_request(REQ_TICK, QID_W'($urandom), TAG_W'($urandom), 1'b0, '0);
                end else begin
                    q = $urandom_range(0, 1) ? hot : QID_W'($urandom);
                    send_request(REQ_SUBMIT, q, TAG_W'($urandom), 1'b0, '0);
                end
                pace();
            end
        end

        drain();
        if (mismatches == 0) $display("*** PASSED ***");
        else $display("*** FAILED ***");
        $finish;
    end

endmodule
